FILE: src/tsr_pkg.sv
// ----------------------------------------------------------------------------
// tsr_pkg
// Shared constants and types for the texture swizzle reorder block.
// ----------------------------------------------------------------------------
package tsr_pkg;

    localparam int MAX_ROW_WORDS = 512;
    localparam int BAND_ROWS     = 8;
    localparam int BLOCK_WORDS   = 4;
    localparam int BLOCK_SIZE    = BLOCK_WORDS * BAND_ROWS;
    localparam int BANK_DEPTH    = MAX_ROW_WORDS * BAND_ROWS;

    localparam int WORD_W   = 32;
    localparam int RW_W     = 10;
    localparam int OFF_W    = $clog2(BANK_DEPTH);
    localparam int ADDR_W   = OFF_W + 1;
    localparam int CNT_W    = OFF_W + 1;
    localparam int ROW_W    = $clog2(BAND_ROWS);
    localparam int COL_W    = $clog2(BLOCK_WORDS);
    localparam int WITHIN_W = $clog2(BLOCK_SIZE);

    localparam logic [RW_W-1:0] ROW_WORDS_RESET = RW_W'(128);
    localparam logic [RW_W-1:0] PITCH_MASK      = RW_W'(10'h3FC);

    localparam logic ACTION_DATA  = 1'b0;
    localparam logic ACTION_FLUSH = 1'b1;

    typedef struct packed {
        logic valid;
        logic last;
    } rd_req_t;

endpackage

FILE: src/tsr_if.sv
// ----------------------------------------------------------------------------
// tsr_if
// Valid/ready channels for linear input words and swizzled output words.
// ----------------------------------------------------------------------------
interface tsr_in_if
    import tsr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              action;
    logic [WORD_W-1:0] data_word;

    modport source (output valid, output action, output data_word, input ready);
    modport sink   (input valid, input action, input data_word, output ready);
endinterface

interface tsr_out_if
    import tsr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] out_word;
    logic              last_of_band;

    modport source (output valid, output out_word, output last_of_band, input ready);
    modport sink   (input valid, input out_word, input last_of_band, output ready);
endinterface

FILE: src/texture_swizzle_reorder_top.sv
// ----------------------------------------------------------------------------
// texture_swizzle_reorder_top
// Linear-to-swizzled texture reorder through a two-bank band store.
//
// Channel texel takes linear 32-bit words in row order (action 0) or flush
// steps (action 1). Channel swizzled gives words in 16-byte by 8-row block
// order, with last_of_band on the final word of each band. One band of
// eight rows fills one bank while the other bank drains the band before.
// Each accepted word yields at most one output word; flush steps drain the
// pending band and discard any partial band.
// cfg_we/cfg_wdata write the row pitch in words (low two bits ignored);
// a write aborts both bands. Write only while idle.
// Throughput: one word per cycle while the receiver takes output, set by the
// single write and single read port of the band store. An accepted word is
// read from the RAM at the accepting edge, then moves to the output register.
// When the receiver stalls, one more word that yields output is accepted and
// held; after that texel.ready drops until the output register is taken.
// Reset clears counters and bank select and sets pitch to 128; store content is
// undefined until written and needs no clearing.
// ----------------------------------------------------------------------------
module texture_swizzle_reorder_top
    import tsr_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [RW_W-1:0] cfg_wdata,
    tsr_in_if.sink          texel,
    tsr_out_if.source       swizzled
);

    logic              fire;
    logic              in_ready;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [WORD_W-1:0] ram_rdata;
    rd_req_t           rd_req;

    assign texel.ready = in_ready;
    assign fire        = texel.valid && in_ready;

    tsr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .fire      (fire),
        .action    (texel.action),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .rd_req    (rd_req)
    );

    tsr_band_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (WORD_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (texel.data_word),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tsr_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_req    (rd_req),
        .fire      (fire),
        .ram_rdata (ram_rdata),
        .in_ready  (in_ready),
        .swizzled  (swizzled)
    );

endmodule

FILE: src/tsr_band_ram.sv
// ----------------------------------------------------------------------------
// tsr_band_ram
// Two-bank band store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tsr_band_ram #(
    parameter int ADDR_W = 13,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/tsr_ctrl.sv
// ----------------------------------------------------------------------------
// tsr_ctrl
// Band counters, bank select and swizzled read address generation.
// ----------------------------------------------------------------------------
module tsr_ctrl
    import tsr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [RW_W-1:0]   cfg_wdata,
    input  logic              fire,
    input  logic              action,
    output logic              ram_we,
    output logic [ADDR_W-1:0] ram_waddr,
    output logic              ram_re,
    output logic [ADDR_W-1:0] ram_raddr,
    output rd_req_t           rd_req
);

    logic [RW_W-1:0]  row_words_reg;
    logic [CNT_W-1:0] write_count_reg, write_count_next;
    logic [CNT_W-1:0] read_count_reg, read_count_next;
    logic             write_bank_reg, write_bank_next;
    logic             pending_reg, pending_next;

    logic [RW_W-1:0]     masked;
    logic [CNT_W-1:0]    rw;
    logic [CNT_W-1:0]    band_size;
    logic                band_ok;
    logic [CNT_W-1:0]    rc_inc;
    logic [CNT_W-1:0]    wc_inc;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
    logic [CNT_W-1:0]    block;
    logic [CNT_W-1:0]    off;
    logic                rd_last;

    always_comb
    begin
        masked    = row_words_reg & PITCH_MASK;
        rw        = (CNT_W'(masked) > CNT_W'(MAX_ROW_WORDS)) ? CNT_W'(MAX_ROW_WORDS)
                                                             : CNT_W'(masked);
        band_size = CNT_W'(rw * CNT_W'(BAND_ROWS));
        band_ok   = (band_size != '0);

        row   = read_count_reg[WITHIN_W-1:COL_W];
        col   = read_count_reg[COL_W-1:0];
        block = read_count_reg >> WITHIN_W;
        off   = CNT_W'(CNT_W'(row) * rw) + CNT_W'(block * CNT_W'(BLOCK_WORDS)) + CNT_W'(col);

        rc_inc  = read_count_reg + CNT_W'(1);
        wc_inc  = write_count_reg + CNT_W'(1);
        rd_last = (rc_inc >= band_size);

        ram_re    = fire && pending_reg && band_ok;
        ram_raddr = {~write_bank_reg, off[OFF_W-1:0]};
        ram_we    = fire && (action == ACTION_DATA) && band_ok;
        ram_waddr = {write_bank_reg, write_count_reg[OFF_W-1:0]};

        rd_req.valid = ram_re;
        rd_req.last  = rd_last;

        write_count_next = write_count_reg;
        read_count_next  = read_count_reg;
        write_bank_next  = write_bank_reg;
        pending_next     = pending_reg;

        if (ram_re)
        begin
            read_count_next = rc_inc;
            if (rd_last)
            begin
                pending_next    = 1'b0;
                read_count_next = '0;
            end
        end

        if (fire && (action == ACTION_FLUSH))
        begin
            write_count_next = '0;
        end
        else if (ram_we)
        begin
            write_count_next = wc_inc;
            if (wc_inc >= band_size)
            begin
                write_count_next = '0;
                write_bank_next  = ~write_bank_reg;
                pending_next     = 1'b1;
                read_count_next  = '0;
            end
        end

        if (cfg_we)
        begin
            write_count_next = '0;
            read_count_next  = '0;
            pending_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_words_reg   <= ROW_WORDS_RESET;
            write_count_reg <= '0;
            read_count_reg  <= '0;
            write_bank_reg  <= 1'b0;
            pending_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                row_words_reg <= cfg_wdata;
            end
            write_count_reg <= write_count_next;
            read_count_reg  <= read_count_next;
            write_bank_reg  <= write_bank_next;
            pending_reg     <= pending_next;
        end
    end

endmodule

FILE: src/tsr_out_stage.sv
// ----------------------------------------------------------------------------
// tsr_out_stage
// Read-data stage and output register; sets input ready from downstream room.
// ----------------------------------------------------------------------------
module tsr_out_stage
    import tsr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  rd_req_t           rd_req,
    input  logic              fire,
    input  logic [WORD_W-1:0] ram_rdata,
    output logic              in_ready,
    tsr_out_if.source         swizzled
);

    logic              s1_valid_reg, s1_valid_next;
    logic              s1_last_reg;
    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] out_word_reg;
    logic              out_last_reg;
    logic              out_free;
    logic              s1_move;

    always_comb
    begin
        out_free = !out_valid_reg || swizzled.ready;
        s1_move  = s1_valid_reg && out_free;
        in_ready = !s1_valid_reg || out_free;

        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = s1_valid_reg;
        end

        s1_valid_next = s1_valid_reg;
        if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
        if (fire)
        begin
            s1_valid_next = rd_req.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && rd_req.valid)
        begin
            s1_last_reg <= rd_req.last;
        end
        if (s1_move)
        begin
            out_word_reg <= ram_rdata;
            out_last_reg <= s1_last_reg;
        end
    end

    assign swizzled.valid        = out_valid_reg;
    assign swizzled.out_word     = out_word_reg;
    assign swizzled.last_of_band = out_last_reg;

endmodule
